// ===== hw/rtl/mbe_pkg.sv =====
package mbe_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned PROD_W  = 2 * COORD_W;
    localparam int unsigned FRAC_W  = 24;
    localparam int unsigned COUNT_W = 8;

    localparam logic [COUNT_W-1:0] LIMIT_RESET  = 8'd30;
    // 4.0 in Q16.48
    localparam logic [PROD_W-1:0]  ESCAPE_BOUND = 64'h0004_0000_0000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQ_I,
        ST_CROSS,
        ST_UPDATE,
        ST_DONE
    } mbe_state_t;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] count;
        logic               member;
    } mbe_result_t;

    // Q16.48 -> Q8.24: floor shift, then saturate to 32 bits
    function automatic logic signed [COORD_W-1:0] sat_q24(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-FRAC_W-1:0] sh;
        logic signed [COORD_W-1:0]       res;
        sh = v[PROD_W-1:FRAC_W];
        if (sh[PROD_W-FRAC_W-1:COORD_W-1] == '0 || sh[PROD_W-FRAC_W-1:COORD_W-1] == '1)
        begin
            res = sh[COORD_W-1:0];
        end
        else if (sh[PROD_W-FRAC_W-1])
        begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/mbe_mul.sv =====
module mbe_mul
    import mbe_pkg::*;
(
    input  logic                      clk,
    input  logic signed [COORD_W-1:0] a,
    input  logic signed [COORD_W-1:0] b,
    output logic signed [PROD_W-1:0]  product
);

    logic signed [PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= a * b;
    end

    assign product = product_reg;

endmodule

// ===== hw/rtl/mbe_iter.sv =====
module mbe_iter
    import mbe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] point_real,
    input  logic signed [COORD_W-1:0] point_imag,
    input  logic [COUNT_W-1:0]        limit,
    input  logic                      result_ack,
    output logic                      idle,
    output mbe_result_t               result
);

    mbe_state_t                state_reg, state_next;
    logic signed [COORD_W-1:0] cr_reg, cr_next;
    logic signed [COORD_W-1:0] ci_reg, ci_next;
    logic signed [COORD_W-1:0] zr_reg, zr_next;
    logic signed [COORD_W-1:0] zi_reg, zi_next;
    logic signed [PROD_W-1:0]  rr_reg, rr_next;
    logic signed [PROD_W-1:0]  ii_reg, ii_next;
    logic [COUNT_W-1:0]        count_reg, count_next;

    logic signed [COORD_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]  product;
    logic [PROD_W-1:0]         mag;
    logic signed [PROD_W-1:0]  cr48, ci48, nr, ni;

    mbe_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    assign mag  = PROD_W'(rr_reg) + PROD_W'(product);
    assign cr48 = {{(PROD_W-COORD_W-FRAC_W){cr_reg[COORD_W-1]}}, cr_reg, {FRAC_W{1'b0}}};
    assign ci48 = {{(PROD_W-COORD_W-FRAC_W){ci_reg[COORD_W-1]}}, ci_reg, {FRAC_W{1'b0}}};
    assign nr   = rr_reg - ii_reg + cr48;
    assign ni   = (product <<< 1) + ci48;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cr_reg <= cr_next;
        ci_reg <= ci_next;
        zr_reg <= zr_next;
        zi_reg <= zi_next;
        rr_reg <= rr_next;
        ii_reg <= ii_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        rr_next    = rr_reg;
        ii_next    = ii_reg;
        count_next = count_reg;
        mul_a      = zr_reg;
        mul_b      = zr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cr_next    = point_real;
                    ci_next    = point_imag;
                    zr_next    = '0;
                    zi_next    = '0;
                    count_next = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (count_reg == limit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SQ_I;
                end
            end
            ST_SQ_I:
            begin
                mul_a      = zi_reg;
                mul_b      = zi_reg;
                rr_next    = product;
                state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                mul_a   = zr_reg;
                mul_b   = zi_reg;
                ii_next = product;
                if (mag > ESCAPE_BOUND)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                zr_next    = sat_q24(nr);
                zi_next    = sat_q24(ni);
                count_next = count_reg + 1'b1;
                state_next = ST_CHECK;
            end
            ST_DONE:
            begin
                if (result_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle          = (state_reg == ST_IDLE);
    assign result.done   = (state_reg == ST_DONE);
    assign result.count  = count_reg;
    assign result.member = (count_reg == limit);

endmodule

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// Sequence: an accepted point runs iterations until the count reaches iteration_limit
// or the point escapes (|z|^2 > 4.0); one shared 32x32 multiplier does three
// products per iteration, which steps through ST_CHECK, ST_SQ_I, ST_CROSS, ST_UPDATE.
// A new point is taken only while the sequencer is idle, after the last result has
// left it for the output register, where one result may wait for out_ready.
// Reset: rst_n asynchronous active low; clears sequencer and out_valid, limit to 30.
module mandelbrot_escape_time
    import mbe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] point_real,
    input  logic signed [COORD_W-1:0] point_imag,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [COUNT_W-1:0]        iteration_count,
    output logic                      inside_set,
    input  logic                      cfg_we,
    input  logic [COUNT_W-1:0]        cfg_wdata
);

    logic [COUNT_W-1:0] limit_reg, limit_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               inside_reg, inside_next;
    logic               idle;
    logic               load;
    mbe_result_t        result;

    mbe_iter u_iter (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid && idle),
        .point_real (point_real),
        .point_imag (point_imag),
        .limit      (limit_reg),
        .result_ack (load),
        .idle       (idle),
        .result     (result)
    );

    assign load = result.done && (!out_valid_reg || out_ready);

    always_comb
    begin
        limit_next     = cfg_we ? cfg_wdata : limit_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        inside_next    = inside_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            count_next     = result.count;
            inside_next    = result.member;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        inside_reg <= inside_next;
    end

    assign in_ready        = idle;
    assign out_valid       = out_valid_reg;
    assign iteration_count = count_reg;
    assign inside_set      = inside_reg;

endmodule
